// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the RTL files; the deframer top level includes them.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// A consequent that must hold in the same cycle as its antecedent.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A consequent that must hold in the cycle after its antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/cfd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfd_pkg
// Types, constants and helpers shared by the frame deframer modules.
// ----------------------------------------------------------------------------
package cfd_pkg;

    localparam int MAX_PAYLOAD = 64;
    localparam int HDR_BYTES   = 4;
    localparam int STORE_DEPTH = MAX_PAYLOAD + HDR_BYTES;
    localparam int PTR_W       = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int LEN_W       = 7;
    localparam int LEN_LO_OFS  = 2;
    localparam int LEN_HI_OFS  = 3;

    localparam logic [7:0] SYNC_BYTE = 8'hAA;

    typedef logic [PTR_W-1:0] ptr_t;
    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [LEN_W-1:0] len_t;

    typedef struct packed {
        logic       wr_en;
        ptr_t       wr_addr;
        logic [7:0] wr_data;
        ptr_t       rd_addr;
    } mem_req_t;

    typedef struct packed {
        logic busy;
        cnt_t count;
        ptr_t head;
    } stat_t;

    // Circular pointer advance; a stays below the depth and b is at most the depth.
    function automatic ptr_t add_mod(input ptr_t a, input cnt_t b);
        logic [CNT_W:0] s;
        s = (CNT_W + 1)'(a) + (CNT_W + 1)'(b);
        if (s >= (CNT_W + 1)'(STORE_DEPTH))
        begin
            s = s - (CNT_W + 1)'(STORE_DEPTH);
        end
        return ptr_t'(s);
    endfunction

endpackage

// ===== rtl/byte_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_in_if
// Valid/ready channel carrying one received serial byte per word.
// ----------------------------------------------------------------------------
interface byte_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/byte_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_out_if
// Valid/ready channel carrying one payload byte and its end-of-frame mark.
// ----------------------------------------------------------------------------
interface byte_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, output data_byte, output last, input ready);
    modport sink   (input valid, input data_byte, input last, output ready);
endinterface

// ===== rtl/checksummed_frame_deframer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// checksummed_frame_deframer_top
// The input takes no new byte until the sequencer is idle again: each received
// byte is written and settled, then bytes are discarded while hunting, the sync
// header is read, frame bytes are summed, payload bytes are emitted and the
// receiver may stall; the one store read port and the shared byte adder do this
// work serially. Payload bytes are offered only after the whole frame is summed.
// Reset clears the sequencer and fill count, sets max_len to 64, leaves the store.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module checksummed_frame_deframer_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  cfd_pkg::len_t      cfg_wdata,
    byte_in_if.sink            rx,
    byte_out_if.source         tx
);
    import cfd_pkg::*;

    len_t       max_len_reg;
    len_t       limit;
    mem_req_t   req;
    logic [7:0] rd_data;
    stat_t      stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= len_t'(MAX_PAYLOAD);
        end
        else if (cfg_we)
        begin
            max_len_reg <= cfg_wdata;
        end
    end

    // Settings above the store's payload room behave as the largest payload.
    assign limit = (max_len_reg > len_t'(MAX_PAYLOAD)) ? len_t'(MAX_PAYLOAD) : max_len_reg;

    cfd_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .limit   (limit),
        .rx      (rx),
        .tx      (tx),
        .req     (req),
        .rd_data (rd_data),
        .stat    (stat)
    );

    cfd_store u_store (
        .clk     (clk),
        .req     (req),
        .rd_data (rd_data)
    );

    `ASSERT_ALWAYS(a_count_range, (stat.count <= cnt_t'(STORE_DEPTH)), "fill count beyond store depth")
    `ASSERT_ALWAYS(a_head_range, (stat.head < ptr_t'(STORE_DEPTH)), "head pointer outside store")
    `ASSERT_IMPLY(a_idle_room, !stat.busy, (stat.count < cnt_t'(STORE_DEPTH)), "idle with full store")
    `ASSERT_NEXT(a_accept_busy, (rx.valid && rx.ready), stat.busy, "not busy after accepting a word")

endmodule

// ===== rtl/cfd_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfd_store
// Circular frame store: one write port and one registered read port.
// ----------------------------------------------------------------------------
module cfd_store (
    input  logic              clk,
    input  cfd_pkg::mem_req_t req,
    output logic [7:0]        rd_data
);
    import cfd_pkg::*;

    logic [7:0] mem [0:STORE_DEPTH-1];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[req.rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/cfd_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfd_ctrl
// Sequencer that hunts for sync, checks length and checksum with one shared
// byte adder, and streams verified payload bytes to the output register.
// ----------------------------------------------------------------------------
module cfd_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  cfd_pkg::len_t      limit,
    byte_in_if.sink            rx,
    byte_out_if.source         tx,
    output cfd_pkg::mem_req_t  req,
    input  logic [7:0]         rd_data,
    output cfd_pkg::stat_t     stat
);
    import cfd_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SETTLE = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_LEN_LO = 3'd3;
    localparam logic [2:0] ST_LEN_HI = 3'd4;
    localparam logic [2:0] ST_SUM    = 3'd5;
    localparam logic [2:0] ST_EMIT   = 3'd6;

    logic [2:0] state_reg, state_next;
    ptr_t       head_reg, head_next;
    cnt_t       count_reg, count_next;
    cnt_t       idx_reg, idx_next;
    cnt_t       total_reg, total_next;
    logic [7:0] plen_lo_reg, plen_lo_next;
    logic [7:0] sum_reg, sum_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_data_reg, out_data_next;
    logic       out_last_reg, out_last_next;

    logic [7:0] byte_sum;
    cnt_t       idx_inc;
    cnt_t       hdr_total;
    logic       too_long;
    logic       out_free;

    assign byte_sum  = sum_reg + rd_data;
    assign idx_inc   = idx_reg + cnt_t'(1);
    assign hdr_total = cnt_t'(HDR_BYTES) + cnt_t'(plen_lo_reg);
    assign too_long  = (rd_data != 8'd0) || (plen_lo_reg > 8'(limit));
    assign out_free  = !out_valid_reg || tx.ready;

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        total_next     = total_reg;
        plen_lo_next   = plen_lo_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg && !tx.ready;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        req.wr_en      = 1'b0;
        req.wr_addr    = add_mod(head_reg, count_reg);
        req.wr_data    = rx.rx_byte;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (rx.valid)
                begin
                    idx_next   = '0;
                    state_next = ST_SETTLE;
                    if (count_reg < cnt_t'(STORE_DEPTH))
                    begin
                        req.wr_en  = 1'b1;
                        count_next = count_reg + cnt_t'(1);
                    end
                end
            end
            // A settle state so that the read port sees the byte just written.
            ST_SETTLE:
            begin
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (count_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
                else if (rd_data != SYNC_BYTE)
                begin
                    head_next  = add_mod(head_reg, cnt_t'(1));
                    count_next = count_reg - cnt_t'(1);
                end
                else if (count_reg < cnt_t'(HDR_BYTES))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next   = cnt_t'(LEN_LO_OFS);
                    state_next = ST_LEN_LO;
                end
            end
            ST_LEN_LO:
            begin
                plen_lo_next = rd_data;
                idx_next     = cnt_t'(LEN_HI_OFS);
                state_next   = ST_LEN_HI;
            end
            ST_LEN_HI:
            begin
                if (too_long)
                begin
                    // False sync: lose the sync byte and rescan what follows.
                    head_next  = add_mod(head_reg, cnt_t'(1));
                    count_next = count_reg - cnt_t'(1);
                    idx_next   = '0;
                    state_next = ST_SCAN;
                end
                else if (count_reg < hdr_total)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    total_next = hdr_total;
                    sum_next   = '0;
                    idx_next   = '0;
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                sum_next = byte_sum;
                if (idx_inc == total_reg)
                begin
                    if (byte_sum != 8'd0)
                    begin
                        head_next  = add_mod(head_reg, cnt_t'(1));
                        count_next = count_reg - cnt_t'(1);
                        idx_next   = '0;
                        state_next = ST_SCAN;
                    end
                    else if (total_reg == cnt_t'(HDR_BYTES))
                    begin
                        // An empty frame is consumed without output.
                        head_next  = add_mod(head_reg, total_reg);
                        count_next = count_reg - total_reg;
                        idx_next   = '0;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        idx_next   = cnt_t'(HDR_BYTES);
                        state_next = ST_EMIT;
                    end
                end
                else
                begin
                    idx_next = idx_inc;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = rd_data;
                    out_last_next  = (idx_inc == total_reg);
                    if (idx_inc == total_reg)
                    begin
                        head_next  = add_mod(head_reg, total_reg);
                        count_next = count_reg - total_reg;
                        idx_next   = '0;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        idx_next = idx_inc;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // The read port follows the next pointer, so rd_data holds the byte at
        // head_reg + idx_reg, except in ST_SETTLE, where a byte just written may not show yet.
        req.rd_addr = add_mod(head_next, idx_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        total_reg    <= total_next;
        plen_lo_reg  <= plen_lo_next;
        sum_reg      <= sum_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign rx.ready     = (state_reg == ST_IDLE);
    assign tx.valid     = out_valid_reg;
    assign tx.data_byte = out_data_reg;
    assign tx.last      = out_last_reg;

    assign stat.busy  = (state_reg != ST_IDLE);
    assign stat.count = count_reg;
    assign stat.head  = head_reg;

endmodule

// ===== sim/checksummed_frame_deframer_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// checksummed_frame_deframer_top_test
// Self-checking bench for the sync/length/checksum deframer. A short directed
// sequence is followed by randomised phases of well-formed and corrupted
// frames, each phase under its own max_len setting. A scoreboard class
// predicts the payload words from every accepted byte and checks each word
// that leaves the block. Both channels idle at random, and the receiver is
// held off for a long stretch once so that the block backs up.
// ----------------------------------------------------------------------------
module checksummed_frame_deframer_top_test;

    import cfd_pkg::*;

    localparam int HOLD_CYCLES   = 1500;
    localparam int SETTLE_CYCLES = 5000;
    localparam int DRAIN_LIMIT   = 100000;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } payload_word_t;

    typedef enum int {
        FRAME_NOISE,
        FRAME_TOO_LONG,
        FRAME_BAD_SUM,
        FRAME_CUT,
        FRAME_GOOD
    } frame_kind_e;

    typedef enum int {
        RDY_ALWAYS,
        RDY_COIN,
        RDY_QUARTER,
        RDY_MOSTLY
    } ready_style_e;

    class payload_scoreboard;
        logic [7:0]    held[STORE_DEPTH];
        int unsigned   fill;
        len_t          max_len;
        payload_word_t payload_due[$];
        int            errors;

        function new();
            fill    = 0;
            max_len = len_t'(MAX_PAYLOAD);
            errors  = 0;
        endfunction

        function int pending();
            return payload_due.size();
        endfunction

        function void drop_lead(input int unsigned n);
            if (n >= fill)
            begin
                fill = 0;
            end
            else
            begin
                for (int i = 0; i < fill - n; i++)
                begin
                    held[i] = held[i + n];
                end
                fill = fill - n;
            end
        endfunction

        // Stores one accepted byte and resolves every frame it completes,
        // including any that turn up while rescanning after a false sync.
        function void note_byte(input logic [7:0] b);
            int unsigned   lim;
            int unsigned   skip;
            int unsigned   plen;
            int unsigned   total;
            logic [7:0]    sum;
            payload_word_t w;
            lim = (max_len > MAX_PAYLOAD) ? MAX_PAYLOAD : max_len;
            if (fill < STORE_DEPTH)
            begin
                held[fill] = b;
                fill++;
            end
            while (1'b1)
            begin
                skip = 0;
                while (skip < fill && held[skip] != SYNC_BYTE)
                begin
                    skip++;
                end
                drop_lead(skip);
                if (fill < HDR_BYTES)
                begin
                    break;
                end
                plen = {held[LEN_HI_OFS], held[LEN_LO_OFS]};
                if (plen > lim)
                begin
                    drop_lead(1);
                    continue;
                end
                total = HDR_BYTES + plen;
                if (fill < total)
                begin
                    break;
                end
                sum = 8'h00;
                for (int i = 0; i < total; i++)
                begin
                    sum = sum + held[i];
                end
                if (sum != 8'h00)
                begin
                    drop_lead(1);
                    continue;
                end
                for (int i = 0; i < plen; i++)
                begin
                    w.data_byte = held[HDR_BYTES + i];
                    w.last      = (i == plen - 1);
                    payload_due.push_back(w);
                end
                drop_lead(total);
            end
        endfunction

        function void check_word(input logic [7:0] got_byte, input logic got_last);
            payload_word_t want;
            if (payload_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected word: expected none, got %02h last %0b",
                         $time, got_byte, got_last);
                return;
            end
            want = payload_due.pop_front();
            if (got_byte !== want.data_byte)
            begin
                errors++;
                $display("%0t: data_byte mismatch: expected %02h, got %02h",
                         $time, want.data_byte, got_byte);
            end
            if (got_last !== want.last)
            begin
                errors++;
                $display("%0t: last mismatch: expected %0b, got %0b",
                         $time, want.last, got_last);
            end
        endfunction

        function void close_out();
            if (payload_due.size() != 0)
            begin
                errors++;
                $display("%0t: %0d words never arrived: expected %02h last %0b, got none",
                         $time, payload_due.size(), payload_due[0].data_byte,
                         payload_due[0].last);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    len_t cfg_wdata;
    logic hold_req;
    int   burst_left;
    int   words_sent;

    payload_scoreboard sb;

    byte_in_if  rx_ch();
    byte_out_if tx_ch();

    checksummed_frame_deframer_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .rx        (rx_ch),
        .tx        (tx_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic logic [7:0] random_byte();
        // Stray sync bytes are made common so that false syncs turn up often.
        if ($urandom_range(0, 7) == 0)
        begin
            return SYNC_BYTE;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // Offers one word and returns at the edge where it is taken. Bursts end
    // with a gap during which valid is low.
    task automatic send_word(input logic [7:0] b);
        if (burst_left == 0)
        begin
            rx_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 16);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        @(posedge clk);
        while (!rx_ch.ready)
        begin
            @(posedge clk);
        end
        sb.note_byte(b);
        burst_left--;
        words_sent++;
    endtask

    task automatic wait_for_drain(input int limit);
        int waited;
        waited = 0;
        while (sb.pending() != 0 && waited < limit)
        begin
            @(posedge clk);
            waited++;
        end
    endtask

    task automatic write_setting(input len_t setting);
        rx_ch.valid <= 1'b0;
        @(posedge clk);
        wait_for_drain(DRAIN_LIMIT);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= setting;
        @(posedge clk);
        cfg_we     <= 1'b0;
        sb.max_len = setting;
        burst_left = 0;
    endtask

    task automatic send_frame(input int lim);
        frame_kind_e kind;
        int          pick;
        int          plen;
        int          sent;
        logic [7:0]  frame[$];
        logic [7:0]  sum;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            kind = FRAME_NOISE;
        else if (pick < 20)
            kind = FRAME_TOO_LONG;
        else if (pick < 30)
            kind = FRAME_BAD_SUM;
        else if (pick < 40)
            kind = FRAME_CUT;
        else
            kind = FRAME_GOOD;

        case (kind)
            FRAME_NOISE:
            begin
                repeat ($urandom_range(1, 6)) send_word(random_byte());
            end
            FRAME_TOO_LONG:
            begin
                plen = ($urandom_range(0, 2) == 0) ? $urandom_range(lim + 1, 16'hFFFF)
                                                    : $urandom_range(lim + 1, lim + 8);
                send_word(SYNC_BYTE);
                send_word(8'($urandom_range(0, 255)));
                send_word(plen[7:0]);
                send_word(plen[15:8]);
                repeat ($urandom_range(0, 4)) send_word(random_byte());
            end
            default:
            begin
                // Mostly short payloads; now and then one at the length limit.
                pick = $urandom_range(0, 9);
                if (pick < 7)
                    plen = $urandom_range(0, (lim < 8) ? lim : 8);
                else if (pick < 9)
                    plen = $urandom_range(0, lim);
                else
                    plen = lim;
                frame.push_back(SYNC_BYTE);
                frame.push_back(8'h00);
                frame.push_back(plen[7:0]);
                frame.push_back(plen[15:8]);
                repeat (plen) frame.push_back(random_byte());
                sum = 8'h00;
                foreach (frame[i])
                begin
                    sum = sum + frame[i];
                end
                frame[1] = 8'h00 - sum;
                if (kind == FRAME_BAD_SUM)
                begin
                    frame[1] = frame[1] ^ 8'($urandom_range(1, 255));
                end
                sent = (kind == FRAME_CUT) ? $urandom_range(3, 3 + plen) : frame.size();
                for (int i = 0; i < sent; i++)
                begin
                    send_word(frame[i]);
                end
            end
        endcase
    endtask

    task automatic run_phase(input len_t setting, input int upto, input bit squeeze,
                             input bit pause_mid);
        int lim;
        int midway;
        bit paused;
        write_setting(setting);
        lim    = (setting > MAX_PAYLOAD) ? MAX_PAYLOAD : setting;
        midway = (words_sent + upto) / 2;
        paused = 1'b0;
        if (squeeze)
        begin
            hold_req <= 1'b1;
        end
        while (words_sent < upto)
        begin
            if (pause_mid && !paused && words_sent >= midway)
            begin
                rx_ch.valid <= 1'b0;
                @(posedge clk);
                wait_for_drain(DRAIN_LIMIT);
                burst_left = 0;
                paused     = 1'b1;
            end
            send_frame(lim);
        end
    endtask

    // Receiver back-pressure: patterns of random length, plus one long hold-off
    // on request during which the block has to stall its input.
    initial
    begin : ready_pattern
        ready_style_e style;
        int           span;
        int           tick;
        int           hold_left;
        style     = RDY_ALWAYS;
        span      = 0;
        tick      = 0;
        hold_left = 0;
        tx_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req <= 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                tx_ch.ready <= 1'b0;
            end
            else
            begin
                if (span == 0)
                begin
                    style = ready_style_e'($urandom_range(0, 3));
                    span  = $urandom_range(4, 80);
                end
                span--;
                tick++;
                case (style)
                    RDY_ALWAYS:  tx_ch.ready <= 1'b1;
                    RDY_COIN:    tx_ch.ready <= 1'($urandom_range(0, 1));
                    RDY_QUARTER: tx_ch.ready <= (tick % 4 == 0);
                    default:     tx_ch.ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && tx_ch.valid && tx_ch.ready)
        begin
            sb.check_word(tx_ch.data_byte, tx_ch.last);
        end
    end

    initial
    begin : stimulus
        logic [7:0] opening[$];
        rx_ch.valid   <= 1'b0;
        rx_ch.rx_byte <= 8'h00;
        cfg_we        <= 1'b0;
        cfg_wdata     <= '0;
        rst_n         <= 1'b0;
        hold_req      <= 1'b0;
        sb         = new();
        burst_left = 0;
        words_sent = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Noise while hunting, an empty frame, a one-byte frame, a length just
        // over the limit, and a frame with a bad checksum that hides a good one.
        opening = '{8'h00, 8'hFF,
                    8'hAA, 8'h56, 8'h00, 8'h00,
                    8'hAA, 8'h56, 8'h01, 8'h00, 8'hFF,
                    8'hAA, 8'h00, 8'h41, 8'h00,
                    8'hAA, 8'h00, 8'h06, 8'h00, 8'hAA, 8'h22, 8'h01, 8'h00, 8'h33, 8'h5B};
        foreach (opening[i])
        begin
            send_word(opening[i]);
        end

        run_phase(len_t'(0), 75, 1'b0, 1'b0);
        run_phase(len_t'(127), 130, 1'b1, 1'b0);
        run_phase(len_t'(1), 180, 1'b0, 1'b0);
        run_phase(len_t'(65), 230, 1'b0, 1'b0);
        run_phase(len_t'(20), 280, 1'b0, 1'b1);
        run_phase(len_t'($urandom_range(2, 63)), 330, 1'b0, 1'b0);
        run_phase(len_t'(64), 385, 1'b0, 1'b0);

        rx_ch.valid <= 1'b0;
        @(posedge clk);
        wait_for_drain(DRAIN_LIMIT);
        repeat (SETTLE_CYCLES) @(posedge clk);
        sb.close_out();
        if (sb.errors == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
